// ----- rtl/dmhc_pkg.sv -----
// types and constants shared by the debug module hart control block
`default_nettype none

package dmhc_pkg;

  localparam logic [7:0] CMDTYPE_MEMORY = 8'd2;
  localparam int unsigned CMD_TYPE_LSB  = 24;
  localparam int unsigned CMD_POSTINC   = 19;

  typedef enum logic [3:0] {
    ST_RUNNING      = 4'd0,
    ST_HALTREQ      = 4'd1,
    ST_HALTED       = 4'd2,
    ST_RESUMEREQ    = 4'd3,
    ST_RESUMEACK    = 4'd4,
    ST_CMD_GENERATE = 4'd5,
    ST_CMD_ERRCHECK = 4'd6,
    ST_CMD_ERROR    = 4'd7,
    ST_CMD_RUNREQ   = 4'd8,
    ST_CMD_RUNNING  = 4'd9,
    ST_CMD_INCR     = 4'd10
  } ctrl_state_t;

  typedef struct packed {
    logic        halt_ack;
    logic        new_command;
    logic        halt_request;
    logic        resume_request;
    logic        hart_halted;
    logic        hart_running;
    logic        hart_cmd_running;
    logic        cmd_not_supported;
    logic [31:0] command_word;
  } in_t;

  typedef struct packed {
    logic halt_req_out;
    logic status_halted;
    logic status_running;
    logic run_cmds_out;
    logic resume_req_out;
    logic resume_ack_out;
    logic cmd_generate;
    logic cmd_run_req;
    logic cmd_busy;
    logic cmd_error_unsupported;
    logic increment_address;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/debug_module_hart_control_fsm_top.sv -----
// top level of the debug module hart control state machine
`default_nettype none

// Control state machine of a RISC-V debug module for one hart. Each input beat
// is one clock's worth of status flags plus the abstract command word; each
// beat gives exactly one output beat carrying the Moore flags of the current
// state, after which the state advances using that beat's flags. The block
// resets to the running state. An input register feeds the state update and
// an output register holds the result, so one beat is taken per clock while
// the output side does not stall; when it stalls, in_stall rises at once
// whenever the input register holds a beat that cannot move on.
module debug_module_hart_control_fsm_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire dmhc_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output dmhc_pkg::out_t     out_data
);
  import dmhc_pkg::*;

  logic        s1_valid_r;
  in_t         s1_data_r;
  logic        s1_move;
  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  out_t        flags;
  logic        out_valid_r;
  out_t        out_data_r;
  logic        mem_postinc;

  assign s1_move  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_move;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  assign mem_postinc =
    (s1_data_r.command_word[CMD_TYPE_LSB +: 8] == CMDTYPE_MEMORY) &&
    s1_data_r.command_word[CMD_POSTINC];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUNNING: begin
        if (s1_data_r.hart_halted) state_nxt = ST_HALTED;
        else if (s1_data_r.halt_request) state_nxt = ST_HALTREQ;
      end
      ST_HALTREQ: begin
        if (s1_data_r.halt_ack || s1_data_r.hart_halted) state_nxt = ST_HALTED;
      end
      ST_HALTED: begin
        if (s1_data_r.resume_request) state_nxt = ST_RESUMEREQ;
        else if (s1_data_r.new_command) state_nxt = ST_CMD_GENERATE;
      end
      ST_RESUMEREQ: begin
        if (s1_data_r.hart_running) state_nxt = ST_RESUMEACK;
      end
      ST_RESUMEACK: begin
        state_nxt = ST_RUNNING;
      end
      ST_CMD_GENERATE: begin
        state_nxt = ST_CMD_ERRCHECK;
      end
      ST_CMD_ERRCHECK: begin
        state_nxt = s1_data_r.cmd_not_supported ? ST_CMD_ERROR : ST_CMD_RUNREQ;
      end
      ST_CMD_ERROR: begin
        state_nxt = ST_HALTED;
      end
      ST_CMD_RUNREQ: begin
        if (s1_data_r.hart_cmd_running) state_nxt = ST_CMD_RUNNING;
      end
      ST_CMD_RUNNING: begin
        if (!s1_data_r.hart_cmd_running) begin
          state_nxt = mem_postinc ? ST_CMD_INCR : ST_HALTED;
        end
      end
      ST_CMD_INCR: begin
        state_nxt = ST_HALTED;
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  // moore flags
  always_comb begin
    flags = '0;
    unique case (state_r)
      ST_RUNNING: begin
        flags.status_running = 1'b1;
      end
      ST_HALTREQ: begin
        flags.status_running = 1'b1;
        flags.halt_req_out   = 1'b1;
      end
      ST_HALTED: begin
        flags.status_halted = 1'b1;
      end
      ST_RESUMEREQ: begin
        flags.status_halted  = 1'b1;
        flags.resume_req_out = 1'b1;
      end
      ST_RESUMEACK: begin
        flags.resume_ack_out = 1'b1;
      end
      ST_CMD_GENERATE: begin
        flags.cmd_busy     = 1'b1;
        flags.cmd_generate = 1'b1;
      end
      ST_CMD_ERRCHECK: begin
        flags.cmd_busy = 1'b1;
      end
      ST_CMD_ERROR: begin
        flags.cmd_busy              = 1'b1;
        flags.cmd_error_unsupported = 1'b1;
      end
      ST_CMD_RUNREQ: begin
        flags.cmd_busy    = 1'b1;
        flags.cmd_run_req = 1'b1;
      end
      ST_CMD_RUNNING: begin
        flags.cmd_busy = 1'b1;
      end
      ST_CMD_INCR: begin
        flags.increment_address = 1'b1;
      end
      default: begin
        flags = '0;
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUNNING;
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid_r) begin
      out_data_r <= flags;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // state only advances when a beat moves into the output register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_move && s1_valid_r) |=> $stable(state_r))
    else $error("state changed without a beat");

  // a held input beat is never dropped
  a_s1_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |=> s1_valid_r)
    else $error("input beat lost while stalled");

  // resume acknowledge lasts one beat and returns to running
  a_resume_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_valid_r && state_r == ST_RESUMEACK) |=> state_r == ST_RUNNING)
    else $error("resume ack did not return to running");

  // running, halted and busy are exclusive in any output beat
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_data_r.status_running, out_data_r.status_halted,
                              out_data_r.cmd_busy}))
    else $error("conflicting status flags");

endmodule

`default_nettype wire

// ----- dv/dmhc_flag_checker.sv -----
// checker that predicts the hart control flags and compares every result beat
module dmhc_flag_checker
  import dmhc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);

  ctrl_state_t hart_state;
  out_t        expected_flags [$];
  out_t        want;

  function automatic out_t state_flags(ctrl_state_t s);
    out_t f;
    f = '0;
    case (s)
      ST_RUNNING: begin
        f.status_running = 1'b1;
      end
      ST_HALTREQ: begin
        f.status_running = 1'b1;
        f.halt_req_out   = 1'b1;
      end
      ST_HALTED: begin
        f.status_halted = 1'b1;
      end
      ST_RESUMEREQ: begin
        f.status_halted  = 1'b1;
        f.resume_req_out = 1'b1;
      end
      ST_RESUMEACK: begin
        f.resume_ack_out = 1'b1;
      end
      ST_CMD_GENERATE: begin
        f.cmd_busy     = 1'b1;
        f.cmd_generate = 1'b1;
      end
      ST_CMD_ERRCHECK: begin
        f.cmd_busy = 1'b1;
      end
      ST_CMD_ERROR: begin
        f.cmd_busy              = 1'b1;
        f.cmd_error_unsupported = 1'b1;
      end
      ST_CMD_RUNREQ: begin
        f.cmd_busy    = 1'b1;
        f.cmd_run_req = 1'b1;
      end
      ST_CMD_RUNNING: begin
        f.cmd_busy = 1'b1;
      end
      ST_CMD_INCR: begin
        f.increment_address = 1'b1;
      end
      default: begin
      end
    endcase
    return f;
  endfunction

  function automatic ctrl_state_t advance_state(ctrl_state_t s, in_t b);
    logic        postinc;
    ctrl_state_t n;
    postinc = (b.command_word[31:CMD_TYPE_LSB] == CMDTYPE_MEMORY) &&
              b.command_word[CMD_POSTINC];
    n = s;
    case (s)
      ST_RUNNING: begin
        if (b.hart_halted) n = ST_HALTED;
        else if (b.halt_request) n = ST_HALTREQ;
      end
      ST_HALTREQ: begin
        if (b.halt_ack || b.hart_halted) n = ST_HALTED;
      end
      ST_HALTED: begin
        if (b.resume_request) n = ST_RESUMEREQ;
        else if (b.new_command) n = ST_CMD_GENERATE;
      end
      ST_RESUMEREQ: begin
        if (b.hart_running) n = ST_RESUMEACK;
      end
      ST_RESUMEACK: begin
        n = ST_RUNNING;
      end
      ST_CMD_GENERATE: begin
        n = ST_CMD_ERRCHECK;
      end
      ST_CMD_ERRCHECK: begin
        n = b.cmd_not_supported ? ST_CMD_ERROR : ST_CMD_RUNREQ;
      end
      ST_CMD_ERROR: begin
        n = ST_HALTED;
      end
      ST_CMD_RUNREQ: begin
        if (b.hart_cmd_running) n = ST_CMD_RUNNING;
      end
      ST_CMD_RUNNING: begin
        if (!b.hart_cmd_running) n = postinc ? ST_CMD_INCR : ST_HALTED;
      end
      ST_CMD_INCR: begin
        n = ST_HALTED;
      end
      default: begin
      end
    endcase
    return n;
  endfunction

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic check_flag(string name, logic got, logic exp);
    if (got !== exp) report($sformatf("%s got %b expected %b", name, got, exp));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hart_state = ST_RUNNING;
      expected_flags.delete();
      pending    = 0;
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_flags.push_back(state_flags(hart_state));
        hart_state = advance_state(hart_state, in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_flags.size() == 0) begin
          report("result beat with no expected flags");
        end else begin
          want = expected_flags.pop_front();
          check_flag("halt_req_out", out_data.halt_req_out, want.halt_req_out);
          check_flag("status_halted", out_data.status_halted, want.status_halted);
          check_flag("status_running", out_data.status_running, want.status_running);
          check_flag("run_cmds_out", out_data.run_cmds_out, want.run_cmds_out);
          check_flag("resume_req_out", out_data.resume_req_out, want.resume_req_out);
          check_flag("resume_ack_out", out_data.resume_ack_out, want.resume_ack_out);
          check_flag("cmd_generate", out_data.cmd_generate, want.cmd_generate);
          check_flag("cmd_run_req", out_data.cmd_run_req, want.cmd_run_req);
          check_flag("cmd_busy", out_data.cmd_busy, want.cmd_busy);
          check_flag("cmd_error_unsupported", out_data.cmd_error_unsupported,
                     want.cmd_error_unsupported);
          check_flag("increment_address", out_data.increment_address,
                     want.increment_address);
        end
      end
      pending = expected_flags.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
// top of the hart control testbench: stimulus, stall pattern and verdict
module testbench;
  import dmhc_pkg::*;

  localparam int RANDOM_BEATS = 1725;
  localparam int IDLE_LIMIT   = 1000;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_SOLID, STALL_LIGHT} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  // flags: halt_ack new_command halt_request resume_request
  //        hart_halted hart_running hart_cmd_running cmd_not_supported
  in_t directed_beats [25] = '{
    {8'b0010_1000, 32'h0000_0000},  // halted wins over halt request
    {8'b0101_0000, 32'h0000_0000},  // resume wins over new command
    {8'b0000_0000, 32'h0000_0000},
    {8'b0000_0100, 32'h0000_0000},
    {8'b1111_1111, 32'hFFFF_FFFF},
    {8'b0010_0000, 32'h0000_0000},
    {8'b0000_0000, 32'h0000_0000},
    {8'b1000_0000, 32'h0000_0000},
    {8'b0100_0000, 32'h0000_0000},
    {8'b0000_0000, 32'h0000_0000},
    {8'b0000_0001, 32'h0000_0000},  // unsupported command
    {8'b0000_0000, 32'h0000_0000},
    {8'b0100_0000, 32'h0000_0000},
    {8'b0000_0000, 32'h0000_0000},
    {8'b0000_0000, 32'h0000_0000},
    {8'b0000_0000, 32'h0000_0000},
    {8'b0000_0010, 32'h0000_0000},
    {8'b0000_0010, 32'h0208_0000},
    {8'b0000_0000, 32'h0208_0000},  // memory access with post-increment
    {8'b0000_0000, 32'h0000_0000},
    {8'b0100_0000, 32'h0000_0000},
    {8'b0000_0000, 32'h0000_0000},
    {8'b0000_0000, 32'h0000_0000},
    {8'b0000_0010, 32'h0000_0000},
    {8'b0000_0000, 32'h01FF_FFFF}   // post-increment bit on a non-memory type
  };

  debug_module_hart_control_fsm_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  dmhc_flag_checker flag_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
      STALL_SOLID: out_stall <= (stall_left < 20);
      default:     out_stall <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic in_t random_beat(bit noisy);
    in_t b;
    b.command_word = $urandom;
    if (noisy) begin
      b[39:32] = 8'($urandom_range(0, 255));
    end else begin
      for (int i = 32; i < 40; i++) b[i] = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 3) != 0) b.command_word[31:CMD_TYPE_LSB] = CMDTYPE_MEMORY;
    end
    return b;
  endfunction

  task automatic send_beat(in_t b);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int  sent;
    int  burst;
    bit  noisy;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_beats[i]) send_beat(directed_beats[i]);
    drain_wait();
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 30);
      noisy = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
        send_beat(random_beat(noisy));
        sent++;
      end
      if (!paused && sent >= RANDOM_BEATS / 2) begin
        drain_wait();
        paused = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
    end
    drain_wait();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
